// ----- hw/rtl/fpsi_pkg.sv -----
// Shared types, register codes and fixed-point constants of the spline interpolator.
package fpsi_pkg;

  // Parameter defaults
  localparam int SampleWidthDef  = 24;
  localparam int PositionBitsDef = 16;

  // Fixed-point layout: coefficients and Horner terms carry this many fraction bits
  localparam int FracBits   = 16;
  // Guard bits above the sample width for coefficients and the Horner accumulator
  localparam int CoefGuard  = 28;
  // Hermite tangent: g * (-tension) is scaled down by this many bits
  localparam int TanShift   = 9;
  // 1.0 in the Q3.12 weight format
  localparam int WeightOne  = 4096;
  // Width of the Q3.12 weights with one bit of headroom
  localparam int WeightW    = 17;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE    = 8'd0,
    REG_TENSION = 8'd1,
    REG_BIAS    = 8'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CUBIC   = 2'd0,
    MODE_CATMULL = 2'd1,
    MODE_HERMITE = 2'd2,
    MODE_BEZIER  = 2'd3
  } mode_e;

  localparam mode_e                      ModeReset    = MODE_CATMULL;
  localparam logic signed [CfgDataW-1:0] TensionReset = -16'sd4096;
  localparam logic signed [CfgDataW-1:0] BiasReset    = 16'sd0;

  typedef struct packed {
    mode_e                      mode;
    logic signed [CfgDataW-1:0] tension;
    logic signed [CfgDataW-1:0] bias;
  } cfg_t;

endpackage

// ----- hw/rtl/four_point_spline_interpolator.sv -----
// Top level of the four-point spline interpolator: config registers, pipeline, output rounding.
//
// Usage:
//   Input words carry four neighboring signed samples and a fractional position t
//   (position / 2^POSITION_BITS). A word is taken at a clock edge with in_valid_i high
//   and in_stall_o low. One result word (value, saturated) is offered on out_valid_o
//   and leaves at an edge with out_stall_i low.
//   Registers are written over the cfg port (index 0 mode, 1 tension, 2 bias; other
//   indexes are ignored); cfg_ready_o is always high. Write them only while the
//   pipeline is empty.
//   Pipeline: twelve register stages. Throughput: one word per clock while out_stall_i
//   stays low. Each group of multipliers in the pipeline (Hermite weights, tension
//   scaling, three Horner products) sits in a stage of its own.
//   Reset clears every valid bit and loads mode Catmull-Rom, tension -1.0 and
//   bias 0. While the receiver stalls, the output word holds and the pipeline keeps
//   filling its empty stages; in_stall_o rises once every stage holds a word.
module four_point_spline_interpolator #(
  parameter int SAMPLE_WIDTH  = fpsi_pkg::SampleWidthDef,
  parameter int POSITION_BITS = fpsi_pkg::PositionBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fpsi_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fpsi_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_before_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_end_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_after_i,
  input  logic [POSITION_BITS-1:0]           position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]     value_o,
  output logic                               saturated_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PB = POSITION_BITS;
  localparam int CW = SW + fpsi_pkg::CoefGuard;
  localparam int RW = CW - fpsi_pkg::FracBits;
  localparam logic signed [CW-1:0] FracHalf = CW'(1) <<< (fpsi_pkg::FracBits - 1);
  localparam logic signed [SW-1:0] HiLim    = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] LoLim    = {1'b1, {(SW - 1){1'b0}}};

  // Configuration registers
  fpsi_pkg::cfg_t cfg_q;
  logic           cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= fpsi_pkg::ModeReset;
      cfg_q.tension <= fpsi_pkg::TensionReset;
      cfg_q.bias    <= fpsi_pkg::BiasReset;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        fpsi_pkg::REG_MODE:    cfg_q.mode    <= fpsi_pkg::mode_e'(cfg_data_i[1:0]);
        fpsi_pkg::REG_TENSION: cfg_q.tension <= cfg_data_i;
        fpsi_pkg::REG_BIAS:    cfg_q.bias    <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Coefficient pipeline
  logic                 c_vld, c_stall;
  logic signed [CW-1:0] c_acc;
  logic [2:0][CW-1:0]   c_coef;
  logic [PB-1:0]        c_pos;

  fpsi_coef #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_coef (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_before_i(sample_before_i),
    .sample_start_i (sample_start_i),
    .sample_end_i   (sample_end_i),
    .sample_after_i (sample_after_i),
    .pos_i          (position_i),
    .out_valid_o    (c_vld),
    .out_stall_i    (c_stall),
    .acc_o          (c_acc),
    .coef_o         (c_coef),
    .pos_o          (c_pos)
  );

  // Horner evaluation: three multiply/round/add steps
  logic                 h0_vld, h0_stall, h1_vld, h1_stall, h2_vld, h2_stall;
  logic signed [CW-1:0] h0_acc, h1_acc, h2_acc;
  logic [2:0][CW-1:0]   h0_coef, h1_coef;
  logic [PB-1:0]        h0_pos, h1_pos;

  fpsi_horner #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POSITION_BITS(POSITION_BITS),
    .STEP         (0)
  ) u_horner0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (c_vld),
    .in_stall_o (c_stall),
    .acc_i      (c_acc),
    .coef_i     (c_coef),
    .pos_i      (c_pos),
    .out_valid_o(h0_vld),
    .out_stall_i(h0_stall),
    .acc_o      (h0_acc),
    .coef_o     (h0_coef),
    .pos_o      (h0_pos)
  );

  fpsi_horner #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POSITION_BITS(POSITION_BITS),
    .STEP         (1)
  ) u_horner1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (h0_vld),
    .in_stall_o (h0_stall),
    .acc_i      (h0_acc),
    .coef_i     (h0_coef),
    .pos_i      (h0_pos),
    .out_valid_o(h1_vld),
    .out_stall_i(h1_stall),
    .acc_o      (h1_acc),
    .coef_o     (h1_coef),
    .pos_o      (h1_pos)
  );

  fpsi_horner #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POSITION_BITS(POSITION_BITS),
    .STEP         (2)
  ) u_horner2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (h1_vld),
    .in_stall_o (h1_stall),
    .acc_i      (h1_acc),
    .coef_i     (h1_coef),
    .pos_i      (h1_pos),
    .out_valid_o(h2_vld),
    .out_stall_i(h2_stall),
    .acc_o      (h2_acc),
    .coef_o     (),
    .pos_o      ()
  );

  // Output stage: round to integer, saturate to the sample range
  logic                 out_vld_q, out_en;
  logic signed [CW-1:0] acc_rnd;
  logic signed [RW-1:0] rnd_int;
  logic                 in_range;
  logic signed [SW-1:0] value_d, value_q;
  logic                 sat_q;

  assign out_en   = !out_vld_q || !out_stall_i;
  assign h2_stall = !out_en;

  always_comb begin
    acc_rnd  = h2_acc + FracHalf;
    rnd_int  = acc_rnd[CW-1:fpsi_pkg::FracBits];
    in_range = (&rnd_int[RW-1:SW-1]) || !(|rnd_int[RW-1:SW-1]);
    if (in_range) begin
      value_d = rnd_int[SW-1:0];
    end else if (rnd_int[RW-1]) begin
      value_d = LoLim;
    end else begin
      value_d = HiLim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= h2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      value_q <= value_d;
      sat_q   <= !in_range;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;

  // Checks
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (value_o == HiLim || value_o == LoLim))
    else $error("saturated word not at a range limit");

  a_drain_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output drains");

  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_wr && cfg_index_i == fpsi_pkg::REG_MODE) |=> $stable(cfg_q.mode))
    else $error("mode changed without a mode write");

endmodule

// ----- hw/rtl/fpsi_coef.sv -----
// Coefficient pipeline: per-mode polynomials, Hermite tangents and Q.16 coefficient assembly.
module fpsi_coef #(
  parameter int SAMPLE_WIDTH  = fpsi_pkg::SampleWidthDef,
  parameter int POSITION_BITS = fpsi_pkg::PositionBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fpsi_pkg::cfg_t                        cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_before_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_end_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_after_i,
  input  logic [POSITION_BITS-1:0]              pos_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0] acc_o,
  output logic [2:0][SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0]   coef_o,
  output logic [POSITION_BITS-1:0]              pos_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PB  = POSITION_BITS;
  localparam int CW  = SW + fpsi_pkg::CoefGuard;
  localparam int KW  = SW + 5;                     // Q1 integer polynomials
  localparam int DW  = SW + 1;                     // sample differences
  localparam int WW  = fpsi_pkg::WeightW;
  localparam int PW  = DW + WW;                    // difference times weight
  localparam int GW  = PW + 1;                     // weighted tangent sum
  localparam int QW  = GW + WW;                    // sum times tension
  localparam int MW  = QW - fpsi_pkg::TanShift;    // rounded tangent
  localparam int NST = 5;
  localparam logic signed [QW-1:0] TanHalf = QW'(1) <<< (fpsi_pkg::TanShift - 1);
  localparam logic signed [WW-1:0] WOne    = WW'(fpsi_pkg::WeightOne);

  // Stage handshake
  logic [NST-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NST-1];

  // Stage 1: mode polynomials in Q1 and Hermite difference-times-weight products
  logic signed [KW-1:0] x0, xa, xb, x3, p;
  logic signed [KW-1:0] k3_d, k2_d, k1_d, k0_d, tmp;
  logic signed [DW-1:0] d0, d1, d2;
  logic signed [WW-1:0] wp, wn;
  logic signed [PW-1:0] pp0_d, pp1_d, pp2_d, pp3_d;

  logic signed [KW-1:0] k3_1_q, k2_1_q, k1_1_q, k0_1_q;
  logic signed [PW-1:0] pp0_q, pp1_q, pp2_q, pp3_q;
  logic                 herm_1_q;
  logic [PB-1:0]        pos_1_q;

  always_comb begin
    x0   = KW'(sample_before_i);
    xa   = KW'(sample_start_i);
    xb   = KW'(sample_end_i);
    x3   = KW'(sample_after_i);
    p    = x3 - xb - x0 + xa;
    tmp  = '0;
    k3_d = '0;
    k2_d = '0;
    k1_d = '0;
    k0_d = xa <<< 1;
    case (cfg_i.mode)
      fpsi_pkg::MODE_CUBIC: begin
        k3_d = p <<< 1;
        k2_d = (x0 - xa - p) <<< 1;
        k1_d = (xb - x0) <<< 1;
      end
      fpsi_pkg::MODE_CATMULL: begin
        tmp  = xa - xb;
        k3_d = (tmp <<< 1) + tmp + x3 - x0;
        k2_d = (x0 <<< 1) - (xa <<< 2) - xa + (xb <<< 2) - x3;
        k1_d = xb - x0;
      end
      fpsi_pkg::MODE_HERMITE: begin
        tmp  = xb - xa;
        k3_d = -(tmp <<< 2);
        k2_d = (tmp <<< 2) + (tmp <<< 1);
      end
      fpsi_pkg::MODE_BEZIER: begin
        tmp  = xa - xb;
        k3_d = (x3 + (tmp <<< 1) + tmp - x0) <<< 1;
        tmp  = x0 - (xa <<< 1) + xb;
        k2_d = (tmp <<< 2) + (tmp <<< 1);
        tmp  = xa - x0;
        k1_d = (tmp <<< 2) + (tmp <<< 1);
        k0_d = x0 <<< 1;
      end
      default: begin
        k0_d = '0;
      end
    endcase

    d0    = DW'(sample_start_i) - DW'(sample_before_i);
    d1    = DW'(sample_end_i) - DW'(sample_start_i);
    d2    = DW'(sample_after_i) - DW'(sample_end_i);
    wp    = WOne + WW'(cfg_i.bias);
    wn    = WOne - WW'(cfg_i.bias);
    pp0_d = PW'(d0) * PW'(wp);
    pp1_d = PW'(d1) * PW'(wn);
    pp2_d = PW'(d1) * PW'(wp);
    pp3_d = PW'(d2) * PW'(wn);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      k3_1_q   <= k3_d;
      k2_1_q   <= k2_d;
      k1_1_q   <= k1_d;
      k0_1_q   <= k0_d;
      pp0_q    <= pp0_d;
      pp1_q    <= pp1_d;
      pp2_q    <= pp2_d;
      pp3_q    <= pp3_d;
      herm_1_q <= (cfg_i.mode == fpsi_pkg::MODE_HERMITE);
      pos_1_q  <= pos_i;
    end
  end

  // Stage 2: weighted tangent sums g0 and g1
  logic signed [KW-1:0] k3_2_q, k2_2_q, k1_2_q, k0_2_q;
  logic signed [GW-1:0] g0_q, g1_q;
  logic                 herm_2_q;
  logic [PB-1:0]        pos_2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      k3_2_q   <= k3_1_q;
      k2_2_q   <= k2_1_q;
      k1_2_q   <= k1_1_q;
      k0_2_q   <= k0_1_q;
      g0_q     <= GW'(pp0_q) + GW'(pp1_q);
      g1_q     <= GW'(pp2_q) + GW'(pp3_q);
      herm_2_q <= herm_1_q;
      pos_2_q  <= pos_1_q;
    end
  end

  // Stage 3: scale the sums by minus tension
  logic signed [WW-1:0] neg_tension;
  logic signed [KW-1:0] k3_3_q, k2_3_q, k1_3_q, k0_3_q;
  logic signed [QW-1:0] q0_q, q1_q;
  logic                 herm_3_q;
  logic [PB-1:0]        pos_3_q;

  assign neg_tension = -WW'(cfg_i.tension);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      k3_3_q   <= k3_2_q;
      k2_3_q   <= k2_2_q;
      k1_3_q   <= k1_2_q;
      k0_3_q   <= k0_2_q;
      q0_q     <= QW'(g0_q) * QW'(neg_tension);
      q1_q     <= QW'(g1_q) * QW'(neg_tension);
      herm_3_q <= herm_2_q;
      pos_3_q  <= pos_2_q;
    end
  end

  // Stage 4: round tangents to Q.16, drop them outside Hermite mode
  logic signed [QW-1:0] qr0, qr1;
  logic signed [KW-1:0] k3_4_q, k2_4_q, k1_4_q, k0_4_q;
  logic signed [MW-1:0] m0_q, m1_q;
  logic [PB-1:0]        pos_4_q;

  assign qr0 = q0_q + TanHalf;
  assign qr1 = q1_q + TanHalf;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      k3_4_q  <= k3_3_q;
      k2_4_q  <= k2_3_q;
      k1_4_q  <= k1_3_q;
      k0_4_q  <= k0_3_q;
      m0_q    <= herm_3_q ? qr0[QW-1:fpsi_pkg::TanShift] : '0;
      m1_q    <= herm_3_q ? qr1[QW-1:fpsi_pkg::TanShift] : '0;
      pos_4_q <= pos_3_q;
    end
  end

  // Stage 5: assemble Q.16 coefficients
  logic signed [CW-1:0] k3x, k2x, k1x, k0x, m0x, m1x;
  logic signed [CW-1:0] c3_q, c2_q, c1_q, c0_q;
  logic [PB-1:0]        pos_5_q;

  always_comb begin
    k3x = CW'(k3_4_q) <<< (fpsi_pkg::FracBits - 1);
    k2x = CW'(k2_4_q) <<< (fpsi_pkg::FracBits - 1);
    k1x = CW'(k1_4_q) <<< (fpsi_pkg::FracBits - 1);
    k0x = CW'(k0_4_q) <<< (fpsi_pkg::FracBits - 1);
    m0x = CW'(m0_q);
    m1x = CW'(m1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      c3_q    <= k3x + m0x + m1x;
      c2_q    <= k2x - (m0x <<< 1) - m1x;
      c1_q    <= k1x + m0x;
      c0_q    <= k0x;
      pos_5_q <= pos_4_q;
    end
  end

  assign acc_o  = c3_q;
  assign coef_o = {c2_q, c1_q, c0_q};
  assign pos_o  = pos_5_q;

endmodule

// ----- hw/rtl/fpsi_horner.sv -----
// One Horner step: multiply the accumulator by t, round to Q.16 and add the next coefficient.
module fpsi_horner #(
  parameter int SAMPLE_WIDTH  = fpsi_pkg::SampleWidthDef,
  parameter int POSITION_BITS = fpsi_pkg::PositionBitsDef,
  parameter int STEP          = 0
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0] acc_i,
  input  logic [2:0][SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0]   coef_i,
  input  logic [POSITION_BITS-1:0]                          pos_i,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output logic signed [SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0] acc_o,
  output logic [2:0][SAMPLE_WIDTH+fpsi_pkg::CoefGuard-1:0]   coef_o,
  output logic [POSITION_BITS-1:0]                          pos_o
);

  localparam int CW  = SAMPLE_WIDTH + fpsi_pkg::CoefGuard;
  localparam int PB  = POSITION_BITS;
  localparam int XW  = CW + PB + 1;
  localparam int SEL = 2 - STEP;
  localparam logic signed [XW-1:0] PosHalf = XW'(1) <<< (PB - 1);

  // Two-stage handshake
  logic [1:0] vld_q, vld_d, en;

  always_comb begin
    en[1]    = !vld_q[1] || !out_stall_i;
    en[0]    = !vld_q[0] || en[1];
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    vld_d[1] = en[1] ? vld_q[0] : vld_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[1];

  // Product stage: acc times t
  logic signed [XW-1:0]  prod_q;
  logic [2:0][CW-1:0]    coef_p_q;
  logic [PB-1:0]         pos_p_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q   <= XW'(acc_i) * XW'($signed({1'b0, pos_i}));
      coef_p_q <= coef_i;
      pos_p_q  <= pos_i;
    end
  end

  // Round-and-add stage
  logic signed [XW-1:0] prod_rnd;
  logic signed [CW-1:0] acc_q;
  logic [2:0][CW-1:0]   coef_a_q;
  logic [PB-1:0]        pos_a_q;

  assign prod_rnd = prod_q + PosHalf;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      acc_q    <= $signed(prod_rnd[PB +: CW]) + $signed(coef_p_q[SEL]);
      coef_a_q <= coef_p_q;
      pos_a_q  <= pos_p_q;
    end
  end

  assign acc_o  = acc_q;
  assign coef_o = coef_a_q;
  assign pos_o  = pos_a_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the four-point spline interpolator: directed and random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = fpsi_pkg::SampleWidthDef;
  localparam int PW          = fpsi_pkg::PositionBitsDef;
  localparam int PipeLatency = 12;
  localparam int IdleLimit   = 2000;
  localparam int PhaseWords  = 250;
  localparam int PhaseCount  = 8;

  localparam logic [fpsi_pkg::CfgIdxW-1:0] IdxSpareLow  = 8'd3;
  localparam logic [fpsi_pkg::CfgIdxW-1:0] IdxSpareHigh = '1;

  localparam logic signed [SW-1:0] SampleHi = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SampleLo = {1'b1, {(SW-1){1'b0}}};
  localparam logic [PW-1:0]        PosHalf  = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW-1:0]        PosLast  = '1;

  typedef logic signed [127:0] wide_t;

  localparam wide_t FixOne    = wide_t'(1) <<< fpsi_pkg::FracBits;
  localparam wide_t FixHalf   = wide_t'(1) <<< (fpsi_pkg::FracBits - 1);
  localparam wide_t SampleHiW = (wide_t'(1) <<< (SW - 1)) - 1;
  localparam wide_t SampleLoW = -(wide_t'(1) <<< (SW - 1));

  typedef struct packed {
    logic signed [SW-1:0] sample_before;
    logic signed [SW-1:0] sample_start;
    logic signed [SW-1:0] sample_end;
    logic signed [SW-1:0] sample_after;
    logic [PW-1:0]        position;
  } sample_set_t;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 saturated;
  } value_word_t;

  // DUT ports
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [fpsi_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [fpsi_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SW-1:0]          sample_before_i = '0;
  logic signed [SW-1:0]          sample_start_i = '0;
  logic signed [SW-1:0]          sample_end_i = '0;
  logic signed [SW-1:0]          sample_after_i = '0;
  logic [PW-1:0]                 position_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SW-1:0]          value_o;
  logic                          saturated_o;

  // Predictor copy of the registers
  fpsi_pkg::mode_e                      cur_mode = fpsi_pkg::ModeReset;
  logic signed [fpsi_pkg::CfgDataW-1:0] cur_tension = fpsi_pkg::TensionReset;
  logic signed [fpsi_pkg::CfgDataW-1:0] cur_bias = fpsi_pkg::BiasReset;

  value_word_t pending_values[$];
  value_word_t head_value;

  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int sat_seen = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_run = 0;
  logic [31:0] cycle_count = '0;

  four_point_spline_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_before_i (sample_before_i),
    .sample_start_i  (sample_start_i),
    .sample_end_i    (sample_end_i),
    .sample_after_i  (sample_after_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o),
    .saturated_o     (saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Round x*y / 2^s to the nearest integer, half toward plus infinity
  function automatic wide_t round_mul(wide_t x, wide_t y, int s);
    return (x * y + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  // Hermite tangent in Q.16: -tension/2 times the bias-weighted slope sum
  function automatic wide_t hermite_tangent(wide_t d_prev, wide_t d_next);
    wide_t wb, wt, g;
    wb = $signed(cur_bias);
    wt = $signed(cur_tension);
    g  = d_prev * (fpsi_pkg::WeightOne + wb) + d_next * (fpsi_pkg::WeightOne - wb);
    return round_mul(g, 32768 - wt, fpsi_pkg::TanShift) - g * 64;
  endfunction

  // Interpolate one sample set under the current registers
  function automatic value_word_t interpolate(sample_set_t w);
    wide_t x0, a, b, x3, t, p, m0, m1, c0, c1, c2, c3, acc, r;
    value_word_t res;
    x0 = $signed(w.sample_before);
    a  = $signed(w.sample_start);
    b  = $signed(w.sample_end);
    x3 = $signed(w.sample_after);
    t  = {112'd0, w.position};
    case (cur_mode)
      fpsi_pkg::MODE_CUBIC: begin
        p  = x3 - b - x0 + a;
        c3 = p * FixOne;
        c2 = (x0 - a - p) * FixOne;
        c1 = (b - x0) * FixOne;
        c0 = a * FixOne;
      end
      fpsi_pkg::MODE_CATMULL: begin
        c3 = (3 * (a - b) + x3 - x0) * FixHalf;
        c2 = (2 * x0 - 5 * a + 4 * b - x3) * FixHalf;
        c1 = (b - x0) * FixHalf;
        c0 = a * FixOne;
      end
      fpsi_pkg::MODE_HERMITE: begin
        m0 = hermite_tangent(a - x0, b - a);
        m1 = hermite_tangent(b - a, x3 - b);
        c3 = 2 * (a - b) * FixOne + m0 + m1;
        c2 = 3 * (b - a) * FixOne - 2 * m0 - m1;
        c1 = m0;
        c0 = a * FixOne;
      end
      default: begin
        c3 = (x3 - 3 * b + 3 * a - x0) * FixOne;
        c2 = 3 * (x0 - 2 * a + b) * FixOne;
        c1 = 3 * (a - x0) * FixOne;
        c0 = x0 * FixOne;
      end
    endcase
    // Horner evaluation, rounding after every product with t
    acc = round_mul(c3, t, PW) + c2;
    acc = round_mul(acc, t, PW) + c1;
    acc = round_mul(acc, t, PW) + c0;
    r   = round_mul(acc, 1, fpsi_pkg::FracBits);
    res.saturated = 1'b0;
    if (r > SampleHiW) begin
      r = SampleHiW;
      res.saturated = 1'b1;
    end else if (r < SampleLoW) begin
      r = SampleLoW;
      res.saturated = 1'b1;
    end
    res.value = r[SW-1:0];
    return res;
  endfunction

  function automatic void apply_reg_write(logic [fpsi_pkg::CfgIdxW-1:0]  idx,
                                          logic [fpsi_pkg::CfgDataW-1:0] data);
    case (idx)
      fpsi_pkg::REG_MODE:    cur_mode = fpsi_pkg::mode_e'(data[1:0]);
      fpsi_pkg::REG_TENSION: cur_tension = data;
      fpsi_pkg::REG_BIAS:    cur_bias = data;
      default:     ;
    endcase
  endfunction

  function automatic sample_set_t make_set(logic signed [SW-1:0] x0, logic signed [SW-1:0] a,
                                           logic signed [SW-1:0] b, logic signed [SW-1:0] x3,
                                           logic [PW-1:0] pos);
    sample_set_t w;
    w.sample_before = x0;
    w.sample_start  = a;
    w.sample_end    = b;
    w.sample_after  = x3;
    w.position      = pos;
    return w;
  endfunction

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return SampleHi;
      1:       return SampleLo;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Smooth streams and full-range noise, plus extremes and small values
  function automatic sample_set_t random_set();
    sample_set_t w;
    int base;
    int kind;
    kind = $urandom_range(9);
    base = int'($urandom_range(8388607)) - 4194304;
    if (kind <= 3) begin
      w.sample_before = SW'($urandom);
      w.sample_start  = SW'($urandom);
      w.sample_end    = SW'($urandom);
      w.sample_after  = SW'($urandom);
    end else if (kind <= 7) begin
      w.sample_before = SW'(base + int'($urandom_range(131071)) - 65536);
      w.sample_start  = SW'(base + int'($urandom_range(131071)) - 65536);
      w.sample_end    = SW'(base + int'($urandom_range(131071)) - 65536);
      w.sample_after  = SW'(base + int'($urandom_range(131071)) - 65536);
    end else if (kind == 8) begin
      w.sample_before = pick_extreme();
      w.sample_start  = pick_extreme();
      w.sample_end    = pick_extreme();
      w.sample_after  = pick_extreme();
    end else begin
      w.sample_before = SW'(int'($urandom_range(8191)) - 4096);
      w.sample_start  = SW'(int'($urandom_range(8191)) - 4096);
      w.sample_end    = SW'(int'($urandom_range(8191)) - 4096);
      w.sample_after  = SW'(int'($urandom_range(8191)) - 4096);
    end
    case ($urandom_range(7))
      0:       w.position = '0;
      1:       w.position = PosLast;
      default: w.position = PW'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [fpsi_pkg::CfgDataW-1:0] pick_weight();
    case ($urandom_range(6))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return 16'(fpsi_pkg::WeightOne);
      4:       return 16'(-fpsi_pkg::WeightOne);
      5:       return 16'(-2 * fpsi_pkg::WeightOne);
      default: return fpsi_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  // Send one word; open a new burst after a random gap when the current one runs out
  task automatic send_word(sample_set_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    sample_before_i <= w.sample_before;
    sample_start_i  <= w.sample_start;
    sample_end_i    <= w.sample_end;
    sample_after_i  <= w.sample_after;
    position_i      <= w.position;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_values.push_back(interpolate(w));
    words_sent++;
  endtask

  // Write one register; drop valid only after the last write of a group
  task automatic write_reg(logic [fpsi_pkg::CfgIdxW-1:0] idx,
                           logic [fpsi_pkg::CfgDataW-1:0] data, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg_write(idx, data);
    reg_writes++;
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Mode data carries random junk above the two mode bits
  task automatic write_regs(fpsi_pkg::mode_e m, logic [fpsi_pkg::CfgDataW-1:0] tension,
                            logic [fpsi_pkg::CfgDataW-1:0] bias);
    write_reg(fpsi_pkg::REG_MODE, {14'($urandom), m}, 1'b0);
    write_reg(fpsi_pkg::REG_TENSION, tension, 1'b0);
    write_reg(fpsi_pkg::REG_BIAS, bias, 1'b1);
  endtask

  // Hold the sender until every expected word is back, then let the pipeline settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (PipeLatency) @(posedge clk_i);
  endtask

  task automatic test_reset_settings();
    send_word(make_set('0, '0, '0, '0, '0));
    send_word(make_set(SampleLo, SampleHi, SampleHi, SampleLo, PosHalf));
    send_word(make_set(SampleHi, SampleLo, SampleLo, SampleHi, PosHalf));
    send_word(make_set(SampleLo, SampleHi, SampleLo, SampleHi, PosLast));
  endtask

  task automatic test_form_extremes();
    fpsi_pkg::mode_e m;
    for (int k = 0; k < 4; k++) begin
      m = fpsi_pkg::mode_e'(k);
      wait_drain();
      write_reg(fpsi_pkg::REG_MODE, {14'($urandom), m}, 1'b1);
      send_word(make_set(SampleLo, SampleHi, SampleHi, SampleLo, PosHalf));
      send_word(make_set(SampleHi, SampleLo, SampleLo, SampleHi, PosHalf));
      send_word(make_set(SampleHi, SampleHi, SampleHi, SampleHi, PosLast));
      send_word(make_set(SampleLo, SampleLo, SampleHi, SampleHi, '0));
    end
  endtask

  task automatic test_hermite_weights();
    wait_drain();
    write_regs(fpsi_pkg::MODE_HERMITE, 16'h8000, 16'h7FFF);
    send_word(make_set(SampleLo, 24'sd1000, -24'sd2000, SampleHi, PosHalf));
    send_word(make_set(24'sd5, SampleHi, SampleLo, 24'sd7, 16'h4000));
    wait_drain();
    write_regs(fpsi_pkg::MODE_HERMITE, 16'h7FFF, 16'h8000);
    send_word(make_set(SampleLo, 24'sd1000, -24'sd2000, SampleHi, PosHalf));
    send_word(make_set(24'sd5, SampleHi, SampleLo, 24'sd7, 16'hC000));
  endtask

  // Writes to indexes past the register list must leave the registers alone
  task automatic test_ignored_index();
    wait_drain();
    write_regs(fpsi_pkg::MODE_HERMITE, 16'(-fpsi_pkg::WeightOne), 16'd1024);
    write_reg(IdxSpareLow, 16'h8001, 1'b0);
    write_reg(IdxSpareHigh, '1, 1'b1);
    send_word(make_set(-24'sd300, 24'sd100, 24'sd900, -24'sd50, PosHalf));
    send_word(make_set(24'sd4000, -24'sd4000, 24'sd4000, -24'sd4000, 16'h1234));
  endtask

  task automatic test_random_streams();
    int hold_at;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_drain();
      write_regs(fpsi_pkg::mode_e'(ph % 4), pick_weight(), pick_weight());
      hold_at = $urandom_range(PhaseWords - 10, 10);
      for (int n = 0; n < PhaseWords; n++) begin
        if (n == hold_at) wait_drain();
        send_word(random_set());
      end
    end
  endtask

  // Stall the result side; the style follows bits 9:8 of the cycle counter
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(3) == 0);
      2'd2: out_stall_i <= ($urandom_range(3) != 0);
      default: begin
        if (stall_run == 0) begin
          stall_run   <= $urandom_range(24, 1);
          out_stall_i <= ~out_stall_i;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_values.size() == 0) begin
        $error("unexpected result word: value %0d saturated %0b", value_o, saturated_o);
        fail_count++;
      end else begin
        head_value = pending_values.pop_front();
        if (value_o !== head_value.value) begin
          $error("value: expected %0d, got %0d", head_value.value, value_o);
          fail_count++;
        end
        if (saturated_o !== head_value.saturated) begin
          $error("saturated: expected %0b, got %0b", head_value.saturated, saturated_o);
          fail_count++;
        end
        words_checked++;
        if (saturated_o) sat_seen++;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no word moved for %0d cycles, %0d still pending",
               IdleLimit, pending_values.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_form_extremes();
    test_hermite_weights();
    test_ignored_index();
    test_random_streams();
    wait_drain();
    $display("Sent %0d sample sets across all four forms with %0d register writes;",
             words_sent, reg_writes);
    $display("checked %0d interpolated words, %0d of them clamped.", words_checked, sat_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fpsi_pkg.sv
hw/rtl/fpsi_coef.sv
hw/rtl/fpsi_horner.sv
hw/rtl/four_point_spline_interpolator.sv
bench/testbench.sv
